// File: design/pufs_pkg.sv
// ----------------------------------------------------------------------------
// pufs_pkg
// shared word types for the percolation union-find statistics unit
// ----------------------------------------------------------------------------
package pufs_pkg;

    typedef struct packed {
        logic       kind;
        logic [9:0] node;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [10:0] largest_size;
        logic [18:0] mean_size_q8;
    } out_word_t;

    localparam logic KIND_ACTIVATE  = 1'b0;
    localparam logic KIND_NEIGHBOUR = 1'b1;

    localparam int unsigned NODE_W  = 10;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned SQ_W    = 21;
    localparam int unsigned MEAN_W  = 19;
    localparam int unsigned NUM_W   = 29;

endpackage

// File: design/percolation_union_find_stats_unit.sv
// ----------------------------------------------------------------------------
// percolation_union_find_stats_unit
// union-find cluster statistics over node activations and neighbour words
// ----------------------------------------------------------------------------
// usage: in_word carries kind/node/last on a valid/ready channel, out_word
// carries largest_size/mean_size_q8 on a valid/ready channel. a result word
// is produced only for an input word with last set.
// one input word at a time. the cluster table is a single-port synchronous
// memory with a registered read. a find walk reads and checks each entry
// up to the root, then path compression repoints each entry on the path to
// the root. a repeated activation adds one walk; a neighbour adds two walks
// and a merge when it is active and in another cluster. a last word runs
// the bit-serial divider (29 quotient bits), which is skipped when there
// are no non-giant clusters.
// reset: a clearing pass writes every table entry below MAX_NODES inactive,
// one per cycle, with in_ready low until it finishes.
// the output word sits in a register; while it waits, the next input word is
// accepted and processed, and the block stalls only when a new result would
// need the still occupied output register.
// ----------------------------------------------------------------------------
module percolation_union_find_stats_unit
    import pufs_pkg::*;
#(
    parameter int unsigned MAX_NODES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned DEPTH = 1 << AW;

    typedef struct packed {
        logic              act;
        logic [AW-1:0]     par;
        logic [SIZE_W-1:0] sz;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ACT_RD, S_ACT_CHK,
        S_F_RD, S_F_CHK, S_C_RD, S_C_CHK, S_C_WAIT_FIX,
        S_N_CHK, S_MERGE1, S_MERGE2, S_MERGE3, S_MERGE4, S_MERGE5,
        S_DIV, S_DIV_WAIT, S_OUT
    } state_t;

    // find context: which root is being searched
    typedef enum logic [1:0] { F_ACT, F_CUR, F_NB } fctx_t;

    entry_t mem [DEPTH];
    entry_t rd_data;
    logic   mem_we;
    logic [AW-1:0] mem_addr;
    entry_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data <= mem[mem_addr];
    end

    state_t state_reg, state_next;
    fctx_t  fctx_reg, fctx_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          we_reg, we_next;
    entry_t        wd_reg, wd_next;

    logic [AW-1:0] cur_root_reg, cur_root_next;
    logic [AW-1:0] giant_root_reg, giant_root_next;
    logic [SIZE_W-1:0] giant_size_reg, giant_size_next;
    logic [SQ_W-1:0]   sum_sq_reg, sum_sq_next;
    logic [SIZE_W-1:0] sum_sz_reg, sum_sz_next;
    logic [SIZE_W-1:0] seen_reg, seen_next;

    logic [AW-1:0] nb_reg, nb_next;
    logic          last_reg, last_next;
    logic [AW-1:0] walk_reg, walk_next;   // node being walked
    logic [AW-1:0] start_reg, start_next; // walk start for compression
    logic [AW-1:0] root_reg, root_next;   // found root
    logic [AW-1:0] r1_reg, r1_next;
    logic [AW-1:0] r2_reg, r2_next;
    logic [SIZE_W-1:0] s1_reg, s1_next;
    logic [SIZE_W-1:0] s2_reg, s2_next;
    logic [AW:0] steps_reg, steps_next;
    logic [SQ_W-1:0] p1_reg, p1_next;
    logic [SQ_W-1:0] p2_reg, p2_next;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;

    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;

    pufs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({sum_sq_reg, 8'b0}),
        .den   (sum_sz_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mem_we    = we_reg;
    assign mem_addr  = addr_reg;
    assign mem_wdata = wd_reg;

    logic node_ok;
    logic [SIZE_W:0]   msum;
    logic [SQ_W-1:0]   prod;
    logic [AW-1:0]     big;

    assign node_ok = (32'(in_word.node) < MAX_NODES);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        msum = {1'b0, s1_reg} + {1'b0, s2_reg};
        prod = SQ_W'(s1_reg) * SQ_W'(s2_reg);
        big  = (s1_reg < s2_reg) ? r2_reg : r1_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        fctx_next       = fctx_reg;
        addr_next       = addr_reg;
        we_next         = 1'b0;
        wd_next         = wd_reg;
        cur_root_next   = cur_root_reg;
        giant_root_next = giant_root_reg;
        giant_size_next = giant_size_reg;
        sum_sq_next     = sum_sq_reg;
        sum_sz_next     = sum_sz_reg;
        seen_next       = seen_reg;
        nb_next         = nb_reg;
        last_next       = last_reg;
        walk_next       = walk_reg;
        start_next      = start_reg;
        root_next       = root_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        steps_next      = steps_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        div_start       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we_next = 1'b1;
                wd_next = '0;
                if (we_reg)
                begin
                    if (32'(addr_reg) == MAX_NODES - 1)
                    begin
                        we_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_word.last;
                    nb_next   = AW'(in_word.node);
                    addr_next = AW'(in_word.node);
                    if (!node_ok)
                        state_next = in_word.last ? S_DIV : S_IDLE;
                    else if (in_word.kind == KIND_ACTIVATE)
                        state_next = S_ACT_RD;
                    else if (seen_reg == '0)
                        state_next = in_word.last ? S_DIV : S_IDLE;
                    else
                    begin
                        // neighbour: check active bit first
                        state_next = S_ACT_RD;
                        fctx_next  = F_NB;
                    end
                    if (in_word.kind == KIND_ACTIVATE)
                        fctx_next = F_ACT;
                end
            end
            S_ACT_RD:
                state_next = (fctx_reg == F_NB) ? S_N_CHK : S_ACT_CHK;
            S_ACT_CHK:
            begin
                if (rd_data.act)
                begin
                    walk_next  = nb_reg;
                    start_next = nb_reg;
                    steps_next = '0;
                    addr_next  = nb_reg;
                    state_next = S_F_RD;
                end
                else
                begin
                    we_next       = 1'b1;
                    wd_next.act   = 1'b1;
                    wd_next.par   = nb_reg;
                    wd_next.sz    = SIZE_W'(1);
                    cur_root_next = nb_reg;
                    if (giant_size_reg == '0)
                    begin
                        giant_root_next = nb_reg;
                        giant_size_next = SIZE_W'(1);
                    end
                    else
                    begin
                        sum_sz_next = sum_sz_reg + 1'b1;
                        sum_sq_next = sum_sq_reg + 1'b1;
                    end
                    if (seen_reg != '1)
                        seen_next = seen_reg + 1'b1;
                    state_next = last_reg ? S_DIV : S_IDLE;
                end
            end
            S_N_CHK:
            begin
                if (!rd_data.act)
                    state_next = last_reg ? S_DIV : S_IDLE;
                else
                begin
                    fctx_next  = F_CUR;
                    walk_next  = cur_root_reg;
                    start_next = cur_root_reg;
                    addr_next  = cur_root_reg;
                    steps_next = '0;
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
                state_next = S_F_CHK;
            S_F_CHK:
            begin
                if (rd_data.par == walk_reg || 32'(steps_reg) >= MAX_NODES)
                begin
                    root_next  = walk_reg;
                    walk_next  = start_reg;
                    addr_next  = start_reg;
                    steps_next = '0;
                    state_next = S_C_RD;
                end
                else
                begin
                    walk_next  = rd_data.par;
                    addr_next  = rd_data.par;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_C_RD:
            begin
                if (walk_reg == root_reg || 32'(steps_reg) >= MAX_NODES)
                begin
                    // walk done
                    unique case (fctx_reg)
                        F_ACT:
                        begin
                            cur_root_next = root_reg;
                            state_next    = last_reg ? S_DIV : S_IDLE;
                        end
                        F_CUR:
                        begin
                            r1_next    = root_reg;
                            fctx_next  = F_NB;
                            walk_next  = nb_reg;
                            start_next = nb_reg;
                            addr_next  = nb_reg;
                            steps_next = '0;
                            state_next = S_F_RD;
                        end
                        default:
                        begin
                            r2_next    = root_reg;
                            if (root_reg == r1_reg)
                                state_next = last_reg ? S_DIV : S_IDLE;
                            else
                            begin
                                addr_next  = r1_reg;
                                state_next = S_MERGE1;
                            end
                        end
                    endcase
                end
                else
                    state_next = S_C_CHK;
            end
            S_C_CHK:
            begin
                // rd_data holds entry of walk_reg: repoint to root
                we_next     = 1'b1;
                wd_next     = rd_data;
                wd_next.par = root_reg;
                walk_next   = rd_data.par;
                steps_next  = steps_reg + 1'b1;
                state_next  = S_C_WAIT_FIX;
            end
            S_MERGE1:
            begin
                addr_next  = r2_reg;
                state_next = S_MERGE2;
            end
            S_MERGE2:
            begin
                s1_next    = rd_data.sz;
                state_next = S_MERGE3;
            end
            S_MERGE3:
            begin
                s2_next    = rd_data.sz;
                state_next = S_MERGE4;
            end
            S_MERGE4:
            begin
                p1_next    = SQ_W'(s1_reg) * SQ_W'(s1_reg);
                p2_next    = SQ_W'(s2_reg) * SQ_W'(s2_reg);
                we_next     = 1'b1;
                addr_next   = (s1_reg < s2_reg) ? r1_reg : r2_reg;
                wd_next.act = 1'b1;
                wd_next.par = big;
                wd_next.sz  = (s1_reg < s2_reg) ? s1_reg : s2_reg;
                state_next  = S_MERGE5;
            end
            S_MERGE5:
            begin
                we_next       = 1'b1;
                addr_next     = big;
                wd_next.act   = 1'b1;
                wd_next.par   = big;
                wd_next.sz    = msum[SIZE_W-1:0];
                cur_root_next = big;
                if (r1_reg == giant_root_reg)
                begin
                    sum_sz_next     = sum_sz_reg - s2_reg;
                    sum_sq_next     = sum_sq_reg - p2_reg;
                    giant_root_next = big;
                    giant_size_next = msum[SIZE_W-1:0];
                end
                else if (r2_reg == giant_root_reg)
                begin
                    sum_sz_next     = sum_sz_reg - s1_reg;
                    sum_sq_next     = sum_sq_reg - p1_reg;
                    giant_root_next = big;
                    giant_size_next = msum[SIZE_W-1:0];
                end
                else if (msum > {1'b0, giant_size_reg})
                begin
                    sum_sz_next = sum_sz_reg - s1_reg - s2_reg + giant_size_reg;
                    sum_sq_next = sum_sq_reg - p1_reg - p2_reg
                                  + SQ_W'(giant_size_reg) * SQ_W'(giant_size_reg);
                    giant_root_next = big;
                    giant_size_next = msum[SIZE_W-1:0];
                end
                else
                    sum_sq_next = sum_sq_reg + {prod[SQ_W-2:0], 1'b0};
                state_next = last_reg ? S_DIV : S_IDLE;
            end
            S_C_WAIT_FIX:
            begin
                addr_next  = walk_reg;
                state_next = S_C_RD;
            end
            S_DIV:
            begin
                if (sum_sz_reg == '0)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.largest_size = giant_size_reg;
                        out_next.mean_size_q8 = MEAN_W'(256);
                        state_next            = S_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // quotient stays in the divider until the next start
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.largest_size = giant_size_reg;
                    out_next.mean_size_q8 = div_quot[MEAN_W-1:0];
                    state_next            = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            fctx_reg       <= F_ACT;
            addr_reg       <= '0;
            we_reg         <= 1'b0;
            cur_root_reg   <= '0;
            giant_root_reg <= '0;
            giant_size_reg <= '0;
            sum_sq_reg     <= '0;
            sum_sz_reg     <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fctx_reg       <= fctx_next;
            addr_reg       <= addr_next;
            we_reg         <= we_next;
            cur_root_reg   <= cur_root_next;
            giant_root_reg <= giant_root_next;
            giant_size_reg <= giant_size_next;
            sum_sq_reg     <= sum_sq_next;
            sum_sz_reg     <= sum_sz_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wd_reg    <= wd_next;
        nb_reg    <= nb_next;
        last_reg  <= last_next;
        walk_reg  <= walk_next;
        start_reg <= start_next;
        root_reg  <= root_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        steps_reg <= steps_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        out_reg   <= out_next;
    end

endmodule

// File: design/pufs_divider.sv
// ----------------------------------------------------------------------------
// pufs_divider
// restoring divider, one quotient bit per cycle: num / den
// ----------------------------------------------------------------------------
module pufs_divider
    import pufs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [SIZE_W-1:0] den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quot_reg;
    logic [SIZE_W:0]   rem_reg;
    logic [SIZE_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W+1:0] trial;
    logic [SIZE_W:0]   shifted;

    always_comb
    begin
        shifted = {rem_reg[SIZE_W-1:0], quot_reg[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                quot_reg <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!trial[SIZE_W+1])
                begin
                    rem_reg  <= trial[SIZE_W:0];
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: design/pufs_checker.sv
// ----------------------------------------------------------------------------
// pufs_checker
// port-level checks for the percolation union-find statistics unit
// ----------------------------------------------------------------------------
module pufs_checker
    import pufs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // no result is offered when reset is released
    a_no_out_from_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result without input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // a waiting input word stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word dropped or changed while waiting");

    a_giant_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.largest_size <= 11'd1024)
        else $error("giant size out of range");

endmodule

bind percolation_union_find_stats_unit pufs_checker u_pufs_checker (.*);
